>>> sv/de_trial_vector_generator_assert.svh
// assertion macros for the trial vector generator checker
// no dependencies; included by the checker file only
`ifndef DE_TRIAL_VECTOR_GENERATOR_ASSERT_SVH
`define DE_TRIAL_VECTOR_GENERATOR_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define DTVG_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define DTVG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/dtvg_pkg.sv
`timescale 1ns / 1ps
// shared types, widths and codes of the trial vector generator
// no dependencies
package dtvg_pkg;

  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned DRAW_W      = 16;
  localparam int unsigned POS_W       = 6;
  localparam int unsigned RATE_W      = 17;
  localparam int unsigned FACTOR_W    = 18;
  localparam int unsigned MODE_W      = 3;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 18;

  // difference widths: two-term and four-term donor differences
  localparam int unsigned DIFF_W      = VALUE_W + 1;
  localparam int unsigned SUM_W       = VALUE_W + 3;
  localparam int unsigned PULL_W      = DIFF_W + FACTOR_W + 1;
  localparam int unsigned PROD_W      = SUM_W + FACTOR_W + 1;
  localparam int unsigned ACC_W       = PROD_W + 2;
  localparam int unsigned RND_W       = ACC_W - FRAC_W;

  localparam int unsigned MAX_DIM_DEFAULT = 64;

  localparam logic [RATE_W-1:0]   RATE_RESET  = RATE_W'(58982);
  localparam logic [FACTOR_W-1:0] SCALE_RESET = FACTOR_W'(32768);
  localparam logic [FACTOR_W-1:0] PULL_RESET  = FACTOR_W'(32768);

  // half an lsb of Q16.16 in the Q.32 accumulator
  localparam int ROUND_HALF = 32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CROSSOVER_RATE = 3'd0,
    CFG_SCALE_FACTOR   = 3'd1,
    CFG_PULL_FACTOR    = 3'd2,
    CFG_MUTATION_MODE  = 3'd3,
    CFG_CROSSOVER_MODE = 3'd4
  } dtvg_cfg_idx_e;

  typedef enum logic [MODE_W-1:0] {
    MUT_BEST_1      = 3'd0,
    MUT_RAND_1      = 3'd1,
    MUT_CUR_TO_BEST = 3'd2,
    MUT_BEST_2      = 3'd3,
    MUT_RAND_2      = 3'd4
  } dtvg_mut_mode_e;

  typedef enum logic {
    XOVER_EXP = 1'b0,
    XOVER_BIN = 1'b1
  } dtvg_xover_e;

  typedef struct packed {
    logic [RATE_W-1:0]   crossover_rate;
    logic [FACTOR_W-1:0] scale_factor;
    logic [FACTOR_W-1:0] pull_factor;
    logic [MODE_W-1:0]   mutation_mode;
    logic                crossover_mode;
  } dtvg_cfg_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] current_value;
    logic signed [VALUE_W-1:0] best_value;
    logic signed [VALUE_W-1:0] donor_one;
    logic signed [VALUE_W-1:0] donor_two;
    logic signed [VALUE_W-1:0] donor_three;
    logic signed [VALUE_W-1:0] donor_four;
    logic signed [VALUE_W-1:0] donor_five;
    logic [DRAW_W-1:0]         random_draw;
    logic [POS_W-1:0]          forced_position;
    logic                      last_element;
  } dtvg_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] new_value;
    logic                      took_mutant;
    logic                      saturated;
    logic                      last_out;
  } dtvg_out_t;

  // base value and exact products, held between the two logic stages
  typedef struct packed {
    logic signed [VALUE_W-1:0] base;
    logic signed [PROD_W-1:0]  p_scale;
    logic signed [PULL_W-1:0]  p_pull;
  } dtvg_mut_t;

endpackage

>>> sv/dtvg_stream_if.sv
`timescale 1ns / 1ps
// valid/ready stream channel with a typed payload
// payload types come from dtvg_pkg at the point of instantiation
interface dtvg_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/dtvg_mutation.sv
`timescale 1ns / 1ps
// mutant formula select: base value and the two factor products
// depends on dtvg_pkg
module dtvg_mutation import dtvg_pkg::*; (
  input  dtvg_in_t  item_i,
  input  dtvg_cfg_t cfg_i,
  output dtvg_mut_t mut_o
);

  logic signed [SUM_W-1:0]    diff_scale;
  logic signed [DIFF_W-1:0]   diff_pull;
  logic signed [VALUE_W-1:0]  base;
  logic                       pull_on;
  logic signed [FACTOR_W:0]   f_s;
  logic signed [FACTOR_W:0]   lam_s;
  logic signed [SUM_W-1:0]    quad;

  assign quad = SUM_W'(item_i.donor_one) + SUM_W'(item_i.donor_two)
              - SUM_W'(item_i.donor_three) - SUM_W'(item_i.donor_four);

  always_comb begin
    base       = item_i.best_value;
    diff_scale = SUM_W'(item_i.donor_two) - SUM_W'(item_i.donor_three);
    pull_on    = 1'b0;
    case (cfg_i.mutation_mode)
      MUT_RAND_1: begin
        base = item_i.donor_one;
      end
      MUT_CUR_TO_BEST: begin
        base       = item_i.current_value;
        diff_scale = SUM_W'(item_i.donor_one) - SUM_W'(item_i.donor_two);
        pull_on    = 1'b1;
      end
      MUT_BEST_2: begin
        diff_scale = quad;
      end
      MUT_RAND_2: begin
        base       = item_i.donor_five;
        diff_scale = quad;
      end
      default: ;
    endcase
  end

  assign diff_pull = DIFF_W'(item_i.best_value) - DIFF_W'(item_i.current_value);

  assign f_s   = $signed({1'b0, cfg_i.scale_factor});
  // pull term only exists in the current-to-best formula
  assign lam_s = pull_on ? $signed({1'b0, cfg_i.pull_factor}) : '0;

  assign mut_o.base    = base;
  assign mut_o.p_scale = diff_scale * f_s;
  assign mut_o.p_pull  = diff_pull * lam_s;

endmodule

>>> sv/dtvg_round_sat.sv
`timescale 1ns / 1ps
// sums base and products, rounds to Q16.16, saturates and picks the result
// depends on dtvg_pkg
module dtvg_round_sat import dtvg_pkg::*; (
  input  dtvg_mut_t                 mut_i,
  input  logic signed [VALUE_W-1:0] current_i,
  input  logic                      took_i,
  input  logic                      last_i,
  output dtvg_out_t                 res_o
);

  logic signed [ACC_W-1:0]   acc;
  logic signed [RND_W-1:0]   rnd;
  logic                      sat;
  logic signed [VALUE_W-1:0] mut;

  assign acc = (ACC_W'(mut_i.base) <<< FRAC_W) + ACC_W'(mut_i.p_scale)
             + ACC_W'(mut_i.p_pull) + ACC_W'(ROUND_HALF);

  // dropping the fraction bits is a floor, so this rounds half up
  assign rnd = acc[ACC_W-1:FRAC_W];

  // fits when every bit above the result sign matches it
  assign sat = !((&rnd[RND_W-1:VALUE_W-1]) || !(|rnd[RND_W-1:VALUE_W-1]));

  always_comb begin
    if (!sat) begin
      mut = rnd[VALUE_W-1:0];
    end else if (rnd[RND_W-1]) begin
      mut = {1'b1, {(VALUE_W-1){1'b0}}};
    end else begin
      mut = {1'b0, {(VALUE_W-1){1'b1}}};
    end
  end

  assign res_o.new_value   = took_i ? mut : current_i;
  assign res_o.took_mutant = took_i;
  assign res_o.saturated   = sat;
  assign res_o.last_out    = last_i;

endmodule

>>> sv/dtvg_crossover.sv
`timescale 1ns / 1ps
// crossover decision with the exponential run flag and the dimension counter
// depends on dtvg_pkg
module dtvg_crossover import dtvg_pkg::*; #(
  parameter int unsigned MAX_DIM = MAX_DIM_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dtvg_cfg_t         cfg_i,
  input  logic              adv_i,
  input  logic [DRAW_W-1:0] draw_i,
  input  logic [POS_W-1:0]  forced_i,
  input  logic              last_i,
  output logic              take_o
);

  logic             run_active_q, run_active_d;
  logic [POS_W-1:0] position_q, position_d;
  logic [POS_W:0]   pos_inc;
  logic             pass;

  assign pass = {1'b0, draw_i} < cfg_i.crossover_rate;

  always_comb begin
    case (cfg_i.crossover_mode)
      XOVER_EXP: take_o = run_active_q && pass;
      default:   take_o = pass || (position_q == forced_i);
    endcase
  end

  assign pos_inc = {1'b0, position_q} + 1'b1;

  always_comb begin
    run_active_d = run_active_q;
    position_d   = position_q;
    if (adv_i) begin
      if (last_i) begin
        run_active_d = 1'b1;
        position_d   = '0;
      end else begin
        if (cfg_i.crossover_mode == XOVER_EXP && !take_o) begin
          run_active_d = 1'b0;
        end
        // counter is kept in its own width whatever the vector length
        position_d = (32'(pos_inc) == MAX_DIM) ? '0 : pos_inc[POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_active_q <= 1'b1;
      position_q   <= '0;
    end else begin
      run_active_q <= run_active_d;
      position_q   <= position_d;
    end
  end

endmodule

>>> sv/de_trial_vector_generator.sv
`timescale 1ns / 1ps
// Differential-evolution trial vector generator, one vector dimension per beat.
// Pipeline of three registers: input register, product register (after the
// two factor multipliers) and result register; one beat is taken every
// cycle while the result side keeps up. The multipliers of the mutant
// formula and the Q.32 sum with rounding each sit between their own pair
// of registers. The crossover state (run flag, dimension counter) steps as
// each beat enters the product register, so beats must arrive in vector
// order. Configuration is to be written by the user through the plain write
// port while no beat is in flight; the block does not enforce this. Writes
// to indexes beyond the register list are ignored.
module de_trial_vector_generator import dtvg_pkg::*; #(
  parameter int unsigned MAX_DIM = MAX_DIM_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  dtvg_stream_if.sink           item_i,
  dtvg_stream_if.source         result_o
);

  dtvg_cfg_t cfg_q;

  logic                      v1_q, v2_q, v3_q;
  logic                      load1, load2, load3;
  logic                      adv;
  dtvg_in_t                  in_q;
  dtvg_mut_t                 mut_d, mut_q;
  logic signed [VALUE_W-1:0] cur_q;
  logic                      took_d, took_q;
  logic                      last_q;
  dtvg_out_t                 res_d, res_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.crossover_rate <= RATE_RESET;
      cfg_q.scale_factor   <= SCALE_RESET;
      cfg_q.pull_factor    <= PULL_RESET;
      cfg_q.mutation_mode  <= MUT_BEST_1;
      cfg_q.crossover_mode <= XOVER_BIN;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CROSSOVER_RATE: cfg_q.crossover_rate <= cfg_data_i[RATE_W-1:0];
        CFG_SCALE_FACTOR:   cfg_q.scale_factor   <= cfg_data_i[FACTOR_W-1:0];
        CFG_PULL_FACTOR:    cfg_q.pull_factor    <= cfg_data_i[FACTOR_W-1:0];
        CFG_MUTATION_MODE:  cfg_q.mutation_mode  <= cfg_data_i[MODE_W-1:0];
        CFG_CROSSOVER_MODE: cfg_q.crossover_mode <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // each stage loads when empty or when its contents move on
  assign load3 = !v3_q || result_o.ready;
  assign load2 = !v2_q || load3;
  assign load1 = !v1_q || load2;
  assign adv   = load2 && v1_q;

  assign item_i.ready   = load1;
  assign result_o.valid = v3_q;
  assign result_o.data  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (load1) v1_q <= item_i.valid;
      if (load2) v2_q <= v1_q;
      if (load3) v3_q <= v2_q;
    end
  end

  dtvg_mutation u_mutation (
    .item_i (in_q),
    .cfg_i  (cfg_q),
    .mut_o  (mut_d)
  );

  dtvg_crossover #(
    .MAX_DIM (MAX_DIM)
  ) u_crossover (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .adv_i    (adv),
    .draw_i   (in_q.random_draw),
    .forced_i (in_q.forced_position),
    .last_i   (in_q.last_element),
    .take_o   (took_d)
  );

  dtvg_round_sat u_round_sat (
    .mut_i     (mut_q),
    .current_i (cur_q),
    .took_i    (took_q),
    .last_i    (last_q),
    .res_o     (res_d)
  );

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (load1 && item_i.valid) begin
      in_q <= item_i.data;
    end
    if (adv) begin
      mut_q  <= mut_d;
      cur_q  <= in_q.current_value;
      took_q <= took_d;
      last_q <= in_q.last_element;
    end
    if (load3 && v2_q) begin
      res_q <= res_d;
    end
  end

endmodule

>>> sv/dtvg_checker.sv
`timescale 1ns / 1ps
// port-level checker for the trial vector generator, with its bind
// depends on dtvg_pkg and de_trial_vector_generator_assert.svh
`include "de_trial_vector_generator_assert.svh"

module dtvg_checker import dtvg_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input dtvg_out_t out_data_i
);

  logic       in_acc, out_acc;
  logic [2:0] cnt_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // beats taken in and not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (in_acc && !out_acc) begin
      cnt_q <= cnt_q + 3'd1;
    end else if (out_acc && !in_acc) begin
      cnt_q <= cnt_q - 3'd1;
    end
  end

  `DTVG_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "result beat dropped while stalled")
  `DTVG_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_data_i), "result payload changed while stalled")
  `DTVG_ASSERT_IMPL(a_ready_backpressure, clk_i, rst_ni, !in_ready_i, out_valid_i && !out_ready_i, "input stalled without a stalled result")
  `DTVG_ASSERT_IMPL(a_occupancy_max, clk_i, rst_ni, 1'b1, cnt_q <= 3'd3, "more beats in flight than pipeline stages")
  `DTVG_ASSERT_IMPL(a_no_phantom, clk_i, rst_ni, out_valid_i, cnt_q != 3'd0, "result beat without an accepted input")

endmodule

bind de_trial_vector_generator dtvg_checker u_dtvg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (item_i.valid),
  .in_ready_i  (item_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_data_i  (result_o.data)
);
